@@ design/utgb_pkg.sv @@
`timescale 1ns / 1ps
package utgb_pkg;

   // Field and register widths
   localparam int WORD_W   = 64;
   localparam int MOD_W    = 16;
   localparam int CSR_IDX_W = 3;

   // Generator constants
   localparam logic [WORD_W-1:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 7;
   localparam int XS_SHIFT_C = 17;

   // Default register map
   localparam logic [31:0] SYSTICK_ADDR_DEF     = 32'd0;
   localparam logic [31:0] UART_STATUS_ADDR_DEF = 32'd4;
   localparam logic [31:0] UART_DATA_ADDR_DEF   = 32'd8;
   localparam logic [31:0] GPIO_OUT_ADDR_DEF    = 32'd12;
   localparam logic [4:0]  RXNE_BIT_DEF         = 5'd5;
   localparam logic [4:0]  TXE_BIT_DEF          = 5'd7;

   // Transaction function codes
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_POLL  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_BUDGET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_GAP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_JITTER  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_GAP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_JITTER = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCESS_COST  = 3'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_code;
      logic [63:0] cycle_now;
      logic [31:0] bytes_delivered;
      logic [31:0] byte_checksum;
   } rsp_type;

   typedef struct packed {
      logic [63:0] seed;
      logic [31:0] byte_budget;
      logic [7:0]  frame_length;
      logic [15:0] byte_gap;
      logic [15:0] byte_jitter;
      logic [15:0] frame_gap;
      logic [15:0] frame_jitter;
      logic [7:0]  access_cost;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_INIT_DRAW,
      ST_INIT_WAIT,
      ST_TICK,
      ST_CHECK,
      ST_ARRIVE,
      ST_DRAW,
      ST_SCHED_WAIT,
      ST_FINISH
   } state_type;

   // One xorshift64 step
   function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      a = w ^ (w << XS_SHIFT_A);
      b = a ^ (a >> XS_SHIFT_B);
      return b ^ (b << XS_SHIFT_C);
   endfunction

endpackage

@@ design/utgb_modu.sv @@
`timescale 1ns / 1ps
module utgb_modu
   import utgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [MOD_W-1:0]  divisor,
   output logic              done,
   output logic [MOD_W-1:0]  remainder
);

   localparam int BITS_PER_STEP = 2;
   localparam int ITER          = WORD_W / BITS_PER_STEP;
   localparam int CNT_W         = $clog2(ITER);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER - 1);

   logic [WORD_W-1:0] dvd_ff, dvd_in;
   logic [MOD_W-1:0]  div_ff, div_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [MOD_W:0] t1, t2, r1, r2;

   // Two restoring remainder steps per cycle
   always_comb begin
      t1 = {rem_ff, dvd_ff[WORD_W-1]};
      r1 = (t1 >= {1'b0, div_ff}) ? (t1 - {1'b0, div_ff}) : t1;
      t2 = {r1[MOD_W-1:0], dvd_ff[WORD_W-2]};
      r2 = (t2 >= {1'b0, div_ff}) ? (t2 - {1'b0, div_ff}) : t2;
   end

   // Sequence the iterations
   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << BITS_PER_STEP;
         rem_in = r2[MOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ design/utgb_core.sv @@
`timescale 1ns / 1ps
module utgb_core
   import utgb_pkg::*;
#(
   parameter logic [31:0] SYSTICK_ADDR     = SYSTICK_ADDR_DEF,
   parameter logic [31:0] UART_STATUS_ADDR = UART_STATUS_ADDR_DEF,
   parameter logic [31:0] UART_DATA_ADDR   = UART_DATA_ADDR_DEF,
   parameter logic [31:0] GPIO_OUT_ADDR    = GPIO_OUT_ADDR_DEF,
   parameter logic [4:0]  RXNE_BIT         = RXNE_BIT_DEF,
   parameter logic [4:0]  TXE_BIT          = TXE_BIT_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  req_type         item,
   input  cfg_type         cfg,
   input  logic            cfg_write,
   input  logic            out_free,
   output core_status_type status,
   output rsp_type         result
);

   state_type state_ff, state_in;

   logic [1:0]        func_ff, func_in;
   logic [31:0]       addr_ff, addr_in;
   logic [31:0]       wdata_ff, wdata_in;
   logic [WORD_W-1:0] rng_ff, rng_in;
   logic [63:0]       cycle_ff, cycle_in;
   logic [63:0]       arrival_ff, arrival_in;
   logic [7:0]        fpos_ff, fpos_in;
   logic [31:0]       sent_ff, sent_in;
   logic [31:0]       csum_ff, csum_in;
   logic [31:0]       gpio_ff, gpio_in;
   logic [7:0]        rxbyte_ff, rxbyte_in;
   logic              pending_ff, pending_in;
   logic              irq_ff, irq_in;
   logic              init_ff, init_in;
   logic              frame_end_ff, frame_end_in;
   logic              jzero_ff, jzero_in;

   logic [WORD_W-1:0] rng_next;
   logic              is_access;
   logic              arrive_now;
   logic [7:0]        fpos_next;
   logic [MOD_W-1:0]  jitter;
   logic [MOD_W-1:0]  gap;

   logic              mod_start;
   logic [MOD_W-1:0]  mod_divisor;
   logic              mod_done;
   logic [MOD_W-1:0]  mod_rem;

   logic [31:0]       rdata;
   logic              irq_out;
   logic              finish;

   assign rng_next   = xs_step(rng_ff);
   assign is_access  = (func_ff == FUNC_READ) || (func_ff == FUNC_WRITE);
   assign arrive_now = !pending_ff && (sent_ff < cfg.byte_budget) && (cycle_ff >= arrival_ff);
   assign fpos_next  = fpos_ff + 8'd1;
   assign jitter     = jzero_ff ? '0 : mod_rem;
   assign gap        = frame_end_ff ? cfg.frame_gap : cfg.byte_gap;

   // Shared remainder unit for every jitter draw
   utgb_modu u_modu (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rng_next),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (init_ff) begin
                  state_in = ST_SEED;
               end else if ((item.func == FUNC_READ) || (item.func == FUNC_WRITE)) begin
                  state_in = ST_TICK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEED:      state_in = ST_INIT_DRAW;
         ST_INIT_DRAW: state_in = ST_INIT_WAIT;
         ST_INIT_WAIT: begin
            if (mod_done) begin
               state_in = is_access ? ST_TICK : ST_FINISH;
            end
         end
         ST_TICK:  state_in = ST_CHECK;
         ST_CHECK: state_in = arrive_now ? ST_ARRIVE : ST_FINISH;
         ST_ARRIVE: state_in = ST_DRAW;
         ST_DRAW:   state_in = ST_SCHED_WAIT;
         ST_SCHED_WAIT: begin
            if (mod_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      mod_start   = 1'b0;
      mod_divisor = cfg.frame_jitter;
      finish      = 1'b0;
      unique case (state_ff)
         ST_INIT_DRAW: mod_start = 1'b1;
         ST_DRAW: begin
            mod_start   = 1'b1;
            mod_divisor = frame_end_ff ? cfg.frame_jitter : cfg.byte_jitter;
         end
         ST_FINISH: finish = out_free;
         default: ;
      endcase
   end

   // Register decode for the finishing transaction
   always_comb begin
      rdata   = '0;
      irq_out = 1'b0;
      case (func_ff)
         FUNC_READ: begin
            if (addr_ff == SYSTICK_ADDR) begin
               rdata = cycle_ff[31:0];
            end else if (addr_ff == UART_STATUS_ADDR) begin
               rdata = ({31'b0, pending_ff} << RXNE_BIT) | (32'd1 << TXE_BIT);
            end else if (addr_ff == UART_DATA_ADDR) begin
               rdata = {24'b0, rxbyte_ff};
            end else if (addr_ff == GPIO_OUT_ADDR) begin
               rdata = gpio_ff;
            end
         end
         FUNC_POLL: irq_out = irq_ff;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      func_in      = func_ff;
      addr_in      = addr_ff;
      wdata_in     = wdata_ff;
      rng_in       = rng_ff;
      cycle_in     = cycle_ff;
      arrival_in   = arrival_ff;
      fpos_in      = fpos_ff;
      sent_in      = sent_ff;
      csum_in      = csum_ff;
      gpio_in      = gpio_ff;
      rxbyte_in    = rxbyte_ff;
      pending_in   = pending_ff;
      irq_in       = irq_ff;
      init_in      = init_ff;
      frame_end_in = frame_end_ff;
      jzero_in     = jzero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in  = item.func;
               addr_in  = item.address;
               wdata_in = item.write_data;
            end
         end
         ST_SEED: begin
            rng_in = xs_step((cfg.seed == '0) ? GOLDEN_SEED : cfg.seed);
         end
         ST_INIT_DRAW: begin
            rng_in   = rng_next;
            jzero_in = (cfg.frame_jitter == '0);
         end
         ST_INIT_WAIT: begin
            if (mod_done) begin
               arrival_in = 64'(cfg.frame_gap) + 64'(jitter);
               init_in    = 1'b0;
            end
         end
         ST_TICK: begin
            cycle_in = cycle_ff + 64'(cfg.access_cost);
         end
         ST_ARRIVE: begin
            rng_in       = rng_next;
            rxbyte_in    = rng_next[7:0];
            pending_in   = 1'b1;
            irq_in       = 1'b1;
            csum_in      = (csum_ff << 5) - csum_ff + {24'b0, rng_next[7:0]};
            sent_in      = sent_ff + 32'd1;
            frame_end_in = (fpos_next >= cfg.frame_length);
            fpos_in      = (fpos_next >= cfg.frame_length) ? 8'd0 : fpos_next;
         end
         ST_DRAW: begin
            rng_in   = rng_next;
            jzero_in = (mod_divisor == '0);
         end
         ST_SCHED_WAIT: begin
            if (mod_done) begin
               arrival_in = cycle_ff + 64'({1'b0, gap} + {1'b0, jitter});
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if ((func_ff == FUNC_READ) && (addr_ff != SYSTICK_ADDR)
                   && (addr_ff != UART_STATUS_ADDR) && (addr_ff == UART_DATA_ADDR)) begin
                  pending_in = 1'b0;
               end
               if ((func_ff == FUNC_WRITE) && (addr_ff == GPIO_OUT_ADDR)) begin
                  gpio_in = wdata_ff;
               end
               if (func_ff == FUNC_POLL) begin
                  irq_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      // Any register write forces a reseed on the next transaction
      if (cfg_write) begin
         init_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         init_ff    <= 1'b1;
         cycle_ff   <= '0;
         fpos_ff    <= '0;
         sent_ff    <= '0;
         csum_ff    <= '0;
         gpio_ff    <= '0;
         rxbyte_ff  <= '0;
         pending_ff <= 1'b0;
         irq_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         init_ff    <= init_in;
         cycle_ff   <= cycle_in;
         fpos_ff    <= fpos_in;
         sent_ff    <= sent_in;
         csum_ff    <= csum_in;
         gpio_ff    <= gpio_in;
         rxbyte_ff  <= rxbyte_in;
         pending_ff <= pending_in;
         irq_ff     <= irq_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      addr_ff      <= addr_in;
      wdata_ff     <= wdata_in;
      rng_ff       <= rng_in;
      arrival_ff   <= arrival_in;
      frame_end_ff <= frame_end_in;
      jzero_ff     <= jzero_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = finish;

   assign result.read_data       = rdata;
   assign result.irq_code        = irq_out;
   assign result.cycle_now       = cycle_ff;
   assign result.bytes_delivered = sent_ff;
   assign result.byte_checksum   = csum_ff;

endmodule

@@ design/uart_timer_gpio_bus_model.sv @@
// Bus model of a cycle counter, a receive-only UART fed by an xorshift64 byte
// source, and a GPIO output register. Each request transaction is a bus read,
// a bus write, an interrupt poll or a code with no access, and yields exactly
// one response. A read or write passes through the tick and check states, a
// byte arrival adds the arrive, draw and wait states, and the first
// transaction after reset or after any register write adds seed, draw and
// wait states for reseeding, the only ones a poll adds. Each wait state lasts
// until the shared remainder unit, which resolves two bits of the 64-bit
// random word per cycle, ends its jitter draw. A stalled response side holds
// the finishing transaction while the output register is occupied. Requests
// are stalled while a transaction is in progress; a finished response waits
// in the output register while the next request is taken. Register writes
// are taken only while no transaction is in progress, and a pending register
// write stalls the request side so that the two are never taken together.
`timescale 1ns / 1ps
module uart_timer_gpio_bus_model
   import utgb_pkg::*;
#(
   parameter logic [31:0] SYSTICK_ADDR     = SYSTICK_ADDR_DEF,
   parameter logic [31:0] UART_STATUS_ADDR = UART_STATUS_ADDR_DEF,
   parameter logic [31:0] UART_DATA_ADDR   = UART_DATA_ADDR_DEF,
   parameter logic [31:0] GPIO_OUT_ADDR    = GPIO_OUT_ADDR_DEF,
   parameter logic [4:0]  RXNE_BIT         = RXNE_BIT_DEF,
   parameter logic [4:0]  TXE_BIT          = TXE_BIT_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   core_status_type core_status;
   rsp_type         core_result;
   logic            req_accept;
   logic            csr_write;
   logic            out_free;

   // Register writes take priority over a new request transaction
   assign req_stall  = !core_status.idle || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = core_status.idle;
   assign csr_write  = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   utgb_core #(
      .SYSTICK_ADDR     (SYSTICK_ADDR),
      .UART_STATUS_ADDR (UART_STATUS_ADDR),
      .UART_DATA_ADDR   (UART_DATA_ADDR),
      .GPIO_OUT_ADDR    (GPIO_OUT_ADDR),
      .RXNE_BIT         (RXNE_BIT),
      .TXE_BIT          (TXE_BIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .item      (req_data),
      .cfg       (cfg_ff),
      .cfg_write (csr_write),
      .out_free  (out_free),
      .status    (core_status),
      .result    (core_result)
   );

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SEED:         cfg_in.seed         = csr_data;
            CSR_BYTE_BUDGET:  cfg_in.byte_budget  = csr_data[31:0];
            CSR_FRAME_LENGTH: cfg_in.frame_length = csr_data[7:0];
            CSR_BYTE_GAP:     cfg_in.byte_gap     = csr_data[15:0];
            CSR_BYTE_JITTER:  cfg_in.byte_jitter  = csr_data[15:0];
            CSR_FRAME_GAP:    cfg_in.frame_gap    = csr_data[15:0];
            CSR_FRAME_JITTER: cfg_in.frame_jitter = csr_data[15:0];
            CSR_ACCESS_COST:  cfg_in.access_cost  = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (core_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed         <= '0;
         cfg_ff.byte_budget  <= '0;
         cfg_ff.frame_length <= 8'd8;
         cfg_ff.byte_gap     <= 16'd100;
         cfg_ff.byte_jitter  <= 16'd16;
         cfg_ff.frame_gap    <= 16'd1000;
         cfg_ff.frame_jitter <= 16'd256;
         cfg_ff.access_cost  <= 8'd4;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted transaction keeps the request side stalled on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request side not stalled after a transaction was accepted");

   // The core never finishes into an occupied output register
   a_finish_into_free: assert property (@(posedge clock) disable iff (reset)
      core_status.done |-> out_free)
      else $error("response produced while output register was occupied");

   // A new response only appears after the core finished a transaction
   a_rsp_from_core: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(core_status.done))
      else $error("response raised without a finished transaction");

endmodule

@@ verif/uart_timer_gpio_bus_model_tb.sv @@
`timescale 1ns / 1ps
module uart_timer_gpio_bus_model_tb;
   import utgb_pkg::*;

   // Function code with no access behind it
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam int IDLE_PCT      = 13;
   localparam int PHASES        = 7;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 100;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      req_type              item;
      logic                 fixed;
      rsp_type              want;
      logic [CSR_IDX_W-1:0] index;
      logic [WORD_W-1:0]    value;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;

   logic        quiet = 1'b0;
   int unsigned cycle_total = 0;
   int unsigned fail_cnt = 0;

   row_type script_q[$];
   rsp_type response_due_q[$];

   // Peripheral state as the bus sees it
   cfg_type     regs;
   logic [63:0] rng_state;
   logic [63:0] tick_count;
   logic [63:0] arrival_cycle;
   logic [7:0]  frame_pos;
   logic [31:0] rx_count;
   logic [31:0] rx_sum;
   logic [31:0] gpio_reg;
   logic [7:0]  rx_byte;
   logic        rx_full;
   logic        irq_flag;
   logic        reseed_due;

   uart_timer_gpio_bus_model dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Advance the byte source by one xorshift64 step
   function automatic logic [63:0] xorshift_next();
      rng_state = rng_state ^ (rng_state << XS_SHIFT_A);
      rng_state = rng_state ^ (rng_state >> XS_SHIFT_B);
      rng_state = rng_state ^ (rng_state << XS_SHIFT_C);
      return rng_state;
   endfunction

   // Random extra cycles; a zero modulus adds none
   function automatic logic [63:0] jitter(input logic [63:0] r, input logic [15:0] modulus);
      if (modulus == 16'd0)
         return 64'd0;
      return r % {48'd0, modulus};
   endfunction

   // Charge one bus access and let a byte land if it is due
   function automatic void advance_uart();
      logic [63:0] r;
      tick_count = tick_count + 64'(regs.access_cost);
      if (!rx_full && rx_count < regs.byte_budget && tick_count >= arrival_cycle) begin
         r = xorshift_next();
         rx_byte = r[7:0];
         rx_full = 1'b1;
         irq_flag = 1'b1;
         rx_sum = rx_sum * 32'd31 + 32'(rx_byte);
         rx_count = rx_count + 32'd1;
         frame_pos = frame_pos + 8'd1;
         // a full frame, or a zero frame length, takes the long gap
         if (frame_pos >= regs.frame_length) begin
            frame_pos = 8'd0;
            arrival_cycle = tick_count + 64'(regs.frame_gap)
                          + jitter(xorshift_next(), regs.frame_jitter);
         end else begin
            arrival_cycle = tick_count + 64'(regs.byte_gap)
                          + jitter(xorshift_next(), regs.byte_jitter);
         end
      end
   endfunction

   // Work out the response to one transaction and update the state
   function automatic rsp_type bus_response(input req_type item);
      rsp_type o;
      o = '0;
      if (reseed_due) begin
         reseed_due = 1'b0;
         rng_state = (regs.seed != 64'd0) ? regs.seed : GOLDEN_SEED;
         void'(xorshift_next());
         arrival_cycle = 64'(regs.frame_gap) + jitter(xorshift_next(), regs.frame_jitter);
      end
      case (item.func)
         FUNC_READ: begin
            advance_uart();
            // decode in priority order: systick, status, data, gpio
            if (item.address == SYSTICK_ADDR_DEF) begin
               o.read_data = tick_count[31:0];
            end else if (item.address == UART_STATUS_ADDR_DEF) begin
               o.read_data = (32'd1 << TXE_BIT_DEF) | (rx_full ? (32'd1 << RXNE_BIT_DEF) : 32'd0);
            end else if (item.address == UART_DATA_ADDR_DEF) begin
               o.read_data = 32'(rx_byte);
               rx_full = 1'b0;
            end else if (item.address == GPIO_OUT_ADDR_DEF) begin
               o.read_data = gpio_reg;
            end
         end
         FUNC_WRITE: begin
            advance_uart();
            if (item.address == GPIO_OUT_ADDR_DEF)
               gpio_reg = item.write_data;
         end
         FUNC_POLL: begin
            o.irq_code = irq_flag;
            irq_flag = 1'b0;
         end
         FUNC_NONE: begin
         end
      endcase
      o.cycle_now = tick_count;
      o.bytes_delivered = rx_count;
      o.byte_checksum = rx_sum;
      return o;
   endfunction

   // Mirror a register write; any write forces a reseed
   function automatic void set_register(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      case (idx)
         CSR_SEED:         regs.seed = v;
         CSR_BYTE_BUDGET:  regs.byte_budget = v[31:0];
         CSR_FRAME_LENGTH: regs.frame_length = v[7:0];
         CSR_BYTE_GAP:     regs.byte_gap = v[15:0];
         CSR_BYTE_JITTER:  regs.byte_jitter = v[15:0];
         CSR_FRAME_GAP:    regs.frame_gap = v[15:0];
         CSR_FRAME_JITTER: regs.frame_jitter = v[15:0];
         CSR_ACCESS_COST:  regs.access_cost = v[7:0];
      endcase
      reseed_due = 1'b1;
   endfunction

   function automatic void add_item(input logic [1:0] f, input logic [31:0] a,
                                    input logic [31:0] d);
      row_type row;
      row.kind = ROW_REQ;
      row.item = '{func: f, address: a, write_data: d};
      row.fixed = 1'b0;
      row.want = '0;
      row.index = '0;
      row.value = '0;
      script_q.push_back(row);
   endfunction

   // Row whose response is known by inspection: no bytes have arrived yet
   function automatic void add_fixed(input logic [1:0] f, input logic [31:0] a,
                                     input logic [31:0] d, input logic [31:0] rd,
                                     input logic [63:0] cyc);
      row_type row;
      add_item(f, a, d);
      row = script_q.pop_back();
      row.fixed = 1'b1;
      row.want = '{read_data: rd, irq_code: 1'b0, cycle_now: cyc,
                   bytes_delivered: 32'd0, byte_checksum: 32'd0};
      script_q.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      row_type row;
      row.kind = ROW_CSR;
      row.item = '0;
      row.fixed = 1'b0;
      row.want = '0;
      row.index = idx;
      row.value = v;
      script_q.push_back(row);
   endfunction

   // Present one transaction, with random gaps ahead of it
   task automatic send_item(input req_type item, input logic fixed, input rsp_type want);
      rsp_type due;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      due = bus_response(item);
      response_due_q.push_back(fixed ? want : due);
      @(negedge clock);
   endtask

   // Drop the request side and hold until every response is back
   task automatic hold_requests();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (response_due_q.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      set_register(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Random back-pressure on the response side
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // Compare each response with the oldest one due
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (response_due_q.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            fail_cnt++;
         end else begin
            want = response_due_q.pop_front();
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_data.read_data);
               fail_cnt++;
            end
            if (rsp_data.irq_code !== want.irq_code) begin
               $error("irq_code: expected %h, got %h", want.irq_code, rsp_data.irq_code);
               fail_cnt++;
            end
            if (rsp_data.cycle_now !== want.cycle_now) begin
               $error("cycle_now: expected %h, got %h", want.cycle_now, rsp_data.cycle_now);
               fail_cnt++;
            end
            if (rsp_data.bytes_delivered !== want.bytes_delivered) begin
               $error("bytes_delivered: expected %h, got %h",
                      want.bytes_delivered, rsp_data.bytes_delivered);
               fail_cnt++;
            end
            if (rsp_data.byte_checksum !== want.byte_checksum) begin
               $error("byte_checksum: expected %h, got %h",
                      want.byte_checksum, rsp_data.byte_checksum);
               fail_cnt++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_total++;
      if (cycle_total >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      req_type item;
      cfg_type c;
      int      made;
      int      k;
      int      phase_len;
      int      pick;
      logic    held;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;

      regs = '{seed: 64'd0, byte_budget: 32'd0, frame_length: 8'd8, byte_gap: 16'd100,
               byte_jitter: 16'd16, frame_gap: 16'd1000, frame_jitter: 16'd256,
               access_cost: 8'd4};
      rng_state = '0;
      tick_count = '0;
      arrival_cycle = '0;
      frame_pos = '0;
      rx_count = '0;
      rx_sum = '0;
      gpio_reg = '0;
      rx_byte = '0;
      rx_full = 1'b0;
      irq_flag = 1'b0;
      reseed_due = 1'b1;

      // Reset values: no byte budget, an access cost of four
      add_fixed(FUNC_READ,  SYSTICK_ADDR_DEF,     32'h0,         32'd4,         64'd4);
      add_fixed(FUNC_READ,  UART_STATUS_ADDR_DEF, 32'h0,         32'h0000_0080, 64'd8);
      add_fixed(FUNC_WRITE, GPIO_OUT_ADDR_DEF,    32'hFFFF_FFFF, 32'h0,         64'd12);
      add_fixed(FUNC_READ,  GPIO_OUT_ADDR_DEF,    32'h0,         32'hFFFF_FFFF, 64'd16);
      add_fixed(FUNC_POLL,  32'hFFFF_FFFF,        32'hFFFF_FFFF, 32'h0,         64'd16);
      add_fixed(FUNC_NONE,  32'hFFFF_FFFF,        32'hFFFF_FFFF, 32'h0,         64'd16);
      add_fixed(FUNC_READ,  32'hFFFF_FFFF,        32'h0,         32'h0,         64'd20);
      add_fixed(FUNC_WRITE, SYSTICK_ADDR_DEF,     32'hFFFF_FFFF, 32'h0,         64'd24);
      add_fixed(FUNC_READ,  UART_DATA_ADDR_DEF,   32'h0,         32'h0,         64'd28);
      add_fixed(FUNC_WRITE, GPIO_OUT_ADDR_DEF,    32'h0,         32'h0,         64'd32);
      add_fixed(FUNC_READ,  GPIO_OUT_ADDR_DEF,    32'h0,         32'h0,         64'd36);
      // Back-to-back bytes: no gaps, zero jitter, zero frame length
      add_csr(CSR_SEED,         64'hFFFF_FFFF_FFFF_FFFF);
      add_csr(CSR_BYTE_BUDGET,  64'h0000_0000_FFFF_FFFF);
      add_csr(CSR_FRAME_LENGTH, 64'd0);
      add_csr(CSR_BYTE_GAP,     64'd0);
      add_csr(CSR_BYTE_JITTER,  64'd0);
      add_csr(CSR_FRAME_GAP,    64'd0);
      add_csr(CSR_FRAME_JITTER, 64'd0);
      add_csr(CSR_ACCESS_COST,  64'd255);
      add_item(FUNC_READ,  UART_STATUS_ADDR_DEF, 32'h0);
      add_item(FUNC_POLL,  32'h0,                32'h0);
      add_item(FUNC_POLL,  32'h0,                32'h0);
      add_item(FUNC_READ,  UART_DATA_ADDR_DEF,   32'h0);
      add_item(FUNC_READ,  UART_STATUS_ADDR_DEF, 32'h0);
      add_item(FUNC_READ,  SYSTICK_ADDR_DEF,     32'h0);
      add_item(FUNC_READ,  UART_DATA_ADDR_DEF,   32'h0);
      add_item(FUNC_WRITE, GPIO_OUT_ADDR_DEF,    32'h5A5A_A5A5);
      add_item(FUNC_READ,  GPIO_OUT_ADDR_DEF,    32'h0);
      add_item(FUNC_POLL,  32'h0,                32'h0);
      // Budget used up: the line goes quiet
      add_csr(CSR_BYTE_BUDGET,  64'd0);
      add_item(FUNC_READ,  UART_STATUS_ADDR_DEF, 32'h0);
      add_item(FUNC_READ,  UART_DATA_ADDR_DEF,   32'h0);
      add_item(FUNC_READ,  UART_STATUS_ADDR_DEF, 32'h0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (script_q[i]) begin
         if (script_q[i].kind == ROW_CSR) begin
            hold_requests();
            write_register(script_q[i].index, script_q[i].value);
         end else begin
            send_item(script_q[i].item, script_q[i].fixed, script_q[i].want);
         end
      end

      // Random phases, each under its own register setting
      made = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         hold_requests();
         case (ph)
            0: c = '{seed: 64'd0, byte_budget: 32'hFFFF_FFFF, frame_length: 8'd0,
                     byte_gap: 16'd0, byte_jitter: 16'd0, frame_gap: 16'd0,
                     frame_jitter: 16'd0, access_cost: 8'd0};
            1: c = '{seed: 64'hFFFF_FFFF_FFFF_FFFF, byte_budget: 32'hFFFF_FFFF,
                     frame_length: 8'd255, byte_gap: 16'hFFFF, byte_jitter: 16'hFFFF,
                     frame_gap: 16'hFFFF, frame_jitter: 16'hFFFF, access_cost: 8'd255};
            2: c = '{seed: {$urandom(), $urandom()},
                     byte_budget: rx_count + $urandom_range(20, 60),
                     frame_length: 8'd0, byte_gap: 16'($urandom_range(0, 300)),
                     byte_jitter: 16'hFFFF, frame_gap: 16'($urandom_range(0, 500)),
                     frame_jitter: 16'($urandom_range(0, 64)),
                     access_cost: 8'($urandom_range(16, 255))};
            default: begin
               c.seed = ($urandom_range(3) == 0) ? 64'd0 : {$urandom(), $urandom()};
               c.byte_budget = $urandom_range(1) ? 32'hFFFF_FFFF
                                                 : rx_count + $urandom_range(0, 40);
               c.frame_length = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(1, 12));
               c.byte_gap = 16'($urandom_range(0, 400));
               c.byte_jitter = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 64));
               c.frame_gap = 16'($urandom_range(0, 1200));
               c.frame_jitter = ($urandom_range(3) == 0) ? 16'd0
                                                         : 16'($urandom_range(1, 300));
               c.access_cost = 8'($urandom_range(1, 255));
            end
         endcase
         write_register(CSR_SEED,         c.seed);
         write_register(CSR_BYTE_BUDGET,  64'(c.byte_budget));
         write_register(CSR_FRAME_LENGTH, 64'(c.frame_length));
         write_register(CSR_BYTE_GAP,     64'(c.byte_gap));
         write_register(CSR_BYTE_JITTER,  64'(c.byte_jitter));
         write_register(CSR_FRAME_GAP,    64'(c.frame_gap));
         write_register(CSR_FRAME_JITTER, 64'(c.frame_jitter));
         write_register(CSR_ACCESS_COST,  64'(c.access_cost));

         phase_len = (ph < 2) ? 150 : 300;
         held = 1'b0;
         k = 0;
         while (k < phase_len) begin
            // let the pipeline run dry once per phase
            if (k == phase_len / 2 && !held) begin
               hold_requests();
               held = 1'b1;
            end
            quiet = (made >= 700 && made < 1000);

            // mostly a receive driver at work, with some noise
            pick = $urandom_range(99);
            item.write_data = $urandom();
            item.address = $urandom();
            if (pick < 20) begin
               item.func = FUNC_READ;
               item.address = UART_STATUS_ADDR_DEF;
            end else if (pick < 40) begin
               item.func = FUNC_READ;
               item.address = UART_DATA_ADDR_DEF;
            end else if (pick < 55) begin
               item.func = FUNC_POLL;
            end else if (pick < 63) begin
               item.func = FUNC_READ;
               item.address = SYSTICK_ADDR_DEF;
            end else if (pick < 73) begin
               item.func = FUNC_WRITE;
               item.address = GPIO_OUT_ADDR_DEF;
            end else if (pick < 81) begin
               item.func = FUNC_READ;
               item.address = GPIO_OUT_ADDR_DEF;
            end else if (pick < 86) begin
               item.func = FUNC_READ;
            end else if (pick < 91) begin
               item.func = FUNC_WRITE;
            end else if (pick < 94) begin
               item.func = FUNC_WRITE;
               item.address = UART_DATA_ADDR_DEF;
            end else if (pick < 97) begin
               item.func = FUNC_READ;
               item.address = $urandom_range(0, 15);
            end else begin
               item.func = FUNC_NONE;
            end

            send_item(item, 1'b0, '0);
            if (item.func != FUNC_NONE) begin
               k++;
               made++;
            end
         end
      end
      quiet = 1'b0;

      hold_requests();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/utgb_pkg.sv
design/utgb_modu.sv
design/utgb_core.sv
design/uart_timer_gpio_bus_model.sv
verif/uart_timer_gpio_bus_model_tb.sv
